// ===== hw/rtl/i2c_master_transaction_sequencer_defines.svh =====
// assertion macros shared by the sequencer checker
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// next-cycle implication, disabled in reset
`define SEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

// ===== hw/rtl/i2cmts_pkg.sv =====
// types, codes and constants of the i2c master transaction sequencer
`timescale 1ns / 1ps
`default_nettype none

package i2cmts_pkg;

  // longest payload a transaction may carry
  localparam logic [7:0] MAX_LENGTH = 8'd255;
  // retry limit after reset
  localparam logic [7:0] RETRY_LIMIT_RESET = 8'd8;

  // request commands
  localparam logic CMD_BEGIN  = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  // direction of the payload
  localparam logic DIR_READ = 1'b1;

  // bus engine status codes, low three bits cleared
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RSTART     = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
  localparam logic [7:0] ST_ARB_LOST   = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START  = 4'd1,
    PH_SLA_W  = 4'd2,
    PH_PTR    = 4'd3,
    PH_RSTART = 4'd4,
    PH_SLA_R  = 4'd5,
    PH_TX     = 4'd6,
    PH_RX     = 4'd7
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_SEND    = 3'd2,
    ACT_RX_ACK  = 3'd3,
    ACT_RX_NACK = 3'd4,
    ACT_STOP    = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    OC_OK        = 3'd0,
    OC_TRIES     = 3'd1,
    OC_START_TO  = 3'd2,
    OC_BAD_START = 3'd3,
    OC_XFER      = 3'd4
  } outcome_t;

  // one request word
  typedef struct packed {
    logic        cmd;
    logic [6:0]  dev_addr;
    logic        direction;
    logic [1:0]  pointer_len;
    logic [15:0] pointer_value;
    logic [7:0]  length;
    logic [7:0]  status_code;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
    logic        timed_out;
  } req_t;

  // one result word
  typedef struct packed {
    action_t     action;
    logic [7:0]  send_byte;
    logic [7:0]  read_data;
    logic        read_valid;
    logic        done_res;
    outcome_t    outcome;
    logic [7:0]  byte_count;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_master_transaction_sequencer.sv =====
// i2c master transaction sequencer: transaction state and next bus action
// Takes one request word per clock while req_stall is low (a begin command or a bus engine
// status report) and answers each with exactly one result word, held in the output or skid
// register: the next bus action, any received payload byte, the running byte count and,
// when the transaction ends, its outcome. The decision is a single registered pass over
// the phase register and the held request, so the rate is one word per cycle; a two-word
// result buffer (output register plus skid register) lets a request be taken while a result
// waits, and req_stall rises only when both are full. retry_limit is written through the
// cfg channel, always ready, and should only change while no transaction is running.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_transaction_sequencer (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   req_valid,
  output logic                  req_stall,
  input  wire i2cmts_pkg::req_t req,
  output logic                  res_valid,
  input  wire                   res_stall,
  output i2cmts_pkg::res_t      res,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [7:0]            cfg_data
);

  // transaction state
  i2cmts_pkg::phase_t phase, phase_next;
  logic [7:0]  tries, tries_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  done_count, done_count_next;
  logic [1:0]  ptr_sent, ptr_sent_next;
  logic [7:0]  retry_limit;

  // held request fields
  logic [6:0]  held_addr;
  logic        held_dir;
  logic [1:0]  held_plen;
  logic [15:0] held_ptr;

  // result buffer
  i2cmts_pkg::res_t res_word;
  i2cmts_pkg::res_t skid;
  logic             skid_valid;
  i2cmts_pkg::res_t r;

  logic       push, pop, load_req;
  logic [7:0] st;
  logic [7:0] len_sat;
  logic [1:0] np;
  logic [1:0] ps_base;
  logic       do_ptr, do_tx, do_rx;

  assign cfg_ready = 1'b1;
  assign req_stall = skid_valid;
  assign push      = req_valid && !skid_valid;
  assign pop       = res_valid && !res_stall;
  assign res       = res_word;

  assign st       = {req.status_code[7:3], 3'b000};
  assign len_sat  = (req.length > i2cmts_pkg::MAX_LENGTH) ? i2cmts_pkg::MAX_LENGTH
                                                          : req.length;
  assign np       = (held_plen > 2'd2) ? 2'd2 : held_plen;
  assign ps_base  = (phase == i2cmts_pkg::PH_SLA_W) ? 2'd0 : ptr_sent;
  assign load_req = push && (req.cmd == i2cmts_pkg::CMD_BEGIN)
                    && (phase == i2cmts_pkg::PH_IDLE);

  // next state and result word
  always_comb begin
    phase_next      = phase;
    tries_next      = tries;
    bytes_left_next = bytes_left;
    done_count_next = done_count;
    ptr_sent_next   = ptr_sent;
    do_ptr          = 1'b0;
    do_tx           = 1'b0;
    do_rx           = 1'b0;
    r               = '0;
    r.action        = i2cmts_pkg::ACT_NONE;
    r.outcome       = i2cmts_pkg::OC_OK;

    if (req.cmd == i2cmts_pkg::CMD_BEGIN) begin
      // begin only from idle
      if (phase == i2cmts_pkg::PH_IDLE) begin
        done_count_next = 8'd0;
        ptr_sent_next   = 2'd0;
        bytes_left_next = len_sat;
        if (retry_limit == 8'd0) begin
          r.done_res = 1'b1;
          r.outcome  = i2cmts_pkg::OC_TRIES;
          phase_next = i2cmts_pkg::PH_IDLE;
        end else begin
          tries_next = 8'd1;
          r.action   = i2cmts_pkg::ACT_START;
          phase_next = i2cmts_pkg::PH_START;
        end
      end
    end else begin
      case (phase)
        i2cmts_pkg::PH_START, i2cmts_pkg::PH_RSTART: begin
          if (req.timed_out) begin
            r.done_res = 1'b1;
            r.outcome  = i2cmts_pkg::OC_START_TO;
            r.action   = i2cmts_pkg::ACT_STOP;
            phase_next = i2cmts_pkg::PH_IDLE;
          end else if (st == i2cmts_pkg::ST_START || st == i2cmts_pkg::ST_RSTART) begin
            r.action = i2cmts_pkg::ACT_SEND;
            if (phase == i2cmts_pkg::PH_START
                && (held_dir != i2cmts_pkg::DIR_READ || held_plen != 2'd0)) begin
              r.send_byte = {held_addr, 1'b0};
              phase_next  = i2cmts_pkg::PH_SLA_W;
            end else begin
              r.send_byte = {held_addr, 1'b1};
              phase_next  = i2cmts_pkg::PH_SLA_R;
            end
          end else if (st == i2cmts_pkg::ST_ARB_LOST) begin
            ptr_sent_next = 2'd0;
            r.action      = i2cmts_pkg::ACT_START;
            phase_next    = i2cmts_pkg::PH_START;
          end else begin
            r.done_res = 1'b1;
            r.outcome  = i2cmts_pkg::OC_BAD_START;
            phase_next = i2cmts_pkg::PH_IDLE;
          end
        end
        i2cmts_pkg::PH_SLA_W, i2cmts_pkg::PH_PTR, i2cmts_pkg::PH_SLA_R: begin
          if (req.timed_out) begin
            r.done_res = 1'b1;
            r.outcome  = i2cmts_pkg::OC_XFER;
            r.action   = i2cmts_pkg::ACT_STOP;
            phase_next = i2cmts_pkg::PH_IDLE;
          end else if (st == i2cmts_pkg::ST_ARB_LOST) begin
            ptr_sent_next = 2'd0;
            r.action      = i2cmts_pkg::ACT_START;
            phase_next    = i2cmts_pkg::PH_START;
          end else if ((phase == i2cmts_pkg::PH_SLA_W && st == i2cmts_pkg::ST_SLA_W_ACK)
                       || (phase == i2cmts_pkg::PH_PTR
                           && st == i2cmts_pkg::ST_DATA_W_ACK)) begin
            do_ptr = 1'b1;
          end else if (phase == i2cmts_pkg::PH_SLA_R && st == i2cmts_pkg::ST_SLA_R_ACK) begin
            do_rx = 1'b1;
          end else if ((phase == i2cmts_pkg::PH_SLA_W && st == i2cmts_pkg::ST_SLA_W_NACK)
                       || (phase == i2cmts_pkg::PH_SLA_R
                           && st == i2cmts_pkg::ST_SLA_R_NACK)) begin
            // address nack: retry while attempts remain
            if (tries >= retry_limit) begin
              r.done_res = 1'b1;
              r.outcome  = i2cmts_pkg::OC_TRIES;
              phase_next = i2cmts_pkg::PH_IDLE;
            end else begin
              tries_next    = tries + 8'd1;
              ptr_sent_next = 2'd0;
              r.action      = i2cmts_pkg::ACT_START;
              phase_next    = i2cmts_pkg::PH_START;
            end
          end else begin
            r.done_res = 1'b1;
            r.outcome  = i2cmts_pkg::OC_XFER;
            r.action   = i2cmts_pkg::ACT_STOP;
            phase_next = i2cmts_pkg::PH_IDLE;
          end
        end
        i2cmts_pkg::PH_TX: begin
          if (!req.timed_out && st == i2cmts_pkg::ST_DATA_W_ACK) begin
            done_count_next = done_count + 8'd1;
            if (bytes_left != 8'd0) begin
              bytes_left_next = bytes_left - 8'd1;
            end
            do_tx = 1'b1;
          end else begin
            r.done_res = 1'b1;
            r.outcome  = i2cmts_pkg::OC_XFER;
            r.action   = i2cmts_pkg::ACT_STOP;
            phase_next = i2cmts_pkg::PH_IDLE;
          end
        end
        i2cmts_pkg::PH_RX: begin
          if (!req.timed_out
              && (st == i2cmts_pkg::ST_DATA_R_ACK || st == i2cmts_pkg::ST_DATA_R_NACK)) begin
            r.read_valid    = 1'b1;
            r.read_data     = req.rx_byte;
            done_count_next = done_count + 8'd1;
            if (bytes_left != 8'd0) begin
              bytes_left_next = bytes_left - 8'd1;
            end
            if (st == i2cmts_pkg::ST_DATA_R_NACK) begin
              r.done_res = 1'b1;
              r.outcome  = i2cmts_pkg::OC_OK;
              r.action   = i2cmts_pkg::ACT_STOP;
              phase_next = i2cmts_pkg::PH_IDLE;
            end else begin
              do_rx = 1'b1;
            end
          end else begin
            r.done_res = 1'b1;
            r.outcome  = i2cmts_pkg::OC_XFER;
            r.action   = i2cmts_pkg::ACT_STOP;
            phase_next = i2cmts_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_next = i2cmts_pkg::PH_IDLE;
        end
      endcase
    end

    // pointer bytes, then repeated start for reads or the payload for writes
    if (do_ptr) begin
      if (ps_base < np) begin
        ptr_sent_next = ps_base + 2'd1;
        r.action      = i2cmts_pkg::ACT_SEND;
        r.send_byte   = (np == 2'd2 && ps_base == 2'd0) ? held_ptr[15:8] : held_ptr[7:0];
        phase_next    = i2cmts_pkg::PH_PTR;
      end else if (held_dir == i2cmts_pkg::DIR_READ) begin
        r.action   = i2cmts_pkg::ACT_START;
        phase_next = i2cmts_pkg::PH_RSTART;
      end else begin
        do_tx = 1'b1;
      end
    end

    // next payload byte to write or stop
    if (do_tx) begin
      if (bytes_left_next == 8'd0) begin
        r.done_res = 1'b1;
        r.outcome  = i2cmts_pkg::OC_OK;
        r.action   = i2cmts_pkg::ACT_STOP;
        phase_next = i2cmts_pkg::PH_IDLE;
      end else begin
        r.action    = i2cmts_pkg::ACT_SEND;
        r.send_byte = req.tx_byte;
        phase_next  = i2cmts_pkg::PH_TX;
      end
    end

    // next payload byte to read, nack on the last one
    if (do_rx) begin
      if (bytes_left_next == 8'd0) begin
        r.done_res = 1'b1;
        r.outcome  = i2cmts_pkg::OC_OK;
        r.action   = i2cmts_pkg::ACT_STOP;
        phase_next = i2cmts_pkg::PH_IDLE;
      end else begin
        r.action   = (bytes_left_next == 8'd1) ? i2cmts_pkg::ACT_RX_NACK
                                               : i2cmts_pkg::ACT_RX_ACK;
        phase_next = i2cmts_pkg::PH_RX;
      end
    end

    r.byte_count = done_count_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= i2cmts_pkg::PH_IDLE;
      tries      <= 8'd0;
      bytes_left <= 8'd0;
      done_count <= 8'd0;
      ptr_sent   <= 2'd0;
    end else if (push) begin
      phase      <= phase_next;
      tries      <= tries_next;
      bytes_left <= bytes_left_next;
      done_count <= done_count_next;
      ptr_sent   <= ptr_sent_next;
    end
  end

  // retry limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= i2cmts_pkg::RETRY_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      retry_limit <= cfg_data;
    end
  end

  // held request, loaded on an accepted begin
  always_ff @(posedge clk) begin
    if (rst) begin
      held_addr <= 7'd0;
      held_dir  <= 1'b0;
      held_plen <= 2'd0;
      held_ptr  <= 16'd0;
    end else if (load_req) begin
      held_addr <= req.dev_addr;
      held_dir  <= req.direction;
      held_plen <= req.pointer_len;
      held_ptr  <= req.pointer_value;
    end
  end

  // result buffer valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        res_valid <= push;
      end
    end else if (push) begin
      if (res_valid) begin
        skid_valid <= 1'b1;
      end else begin
        res_valid <= 1'b1;
      end
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        res_word <= skid;
      end else if (push) begin
        res_word <= r;
      end
    end else if (push) begin
      if (res_valid) begin
        skid <= r;
      end else begin
        res_word <= r;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/i2cmts_checker.sv =====
// port-level checker for the i2c master transaction sequencer, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_transaction_sequencer_defines.svh"

module i2cmts_checker (
  input wire                   clk,
  input wire                   rst,
  input wire                   req_valid,
  input wire                   req_stall,
  input wire                   res_valid,
  input wire                   res_stall,
  input wire i2cmts_pkg::res_t res
);

  // a stalled result word holds
  `SEQ_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res))

  // an outcome is only reported with the end of a transaction
  `SEQ_ASSERT_NOW(a_outcome_done, clk, rst, res_valid && !res.done_res,
                  res.outcome == i2cmts_pkg::OC_OK)

  // a received byte comes with a receive or stop action
  `SEQ_ASSERT_NOW(a_read_action, clk, rst, res_valid && res.read_valid,
                  res.action == i2cmts_pkg::ACT_RX_ACK || res.action == i2cmts_pkg::ACT_RX_NACK
                  || res.action == i2cmts_pkg::ACT_STOP)

  // send byte is zero unless a byte is sent
  `SEQ_ASSERT_NOW(a_send_zero, clk, rst, res_valid && res.action != i2cmts_pkg::ACT_SEND,
                  res.send_byte == 8'd0)

  // an accepted request always yields a result word next cycle
  `SEQ_ASSERT_NEXT(a_req_res, clk, rst, req_valid && !req_stall, res_valid)

endmodule

bind i2c_master_transaction_sequencer i2cmts_checker u_checker (.*);

`default_nettype wire

// ===== dv/i2c_master_transaction_sequencer_tb.sv =====
// self-checking testbench for the i2c master transaction sequencer
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer_tb;
  import i2cmts_pkg::*;

  // transaction state as the sequencer keeps it
  typedef struct {
    phase_t      phase;
    logic [7:0]  tries;
    logic [7:0]  bytes_left;
    logic [7:0]  done_count;
    logic [1:0]  pointer_sent;
    logic [6:0]  addr;
    logic        dir;
    logic [1:0]  plen;
    logic [15:0] ptr;
    logic [7:0]  retry_limit;
  } seq_state_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  req_t       req = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  res_t       res;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  // words waiting to be sent and bus actions waiting to come back
  req_t       pending_q[$];
  res_t       expected_q[$];
  // checker copy of the state, and the copy the stimulus is planned on
  seq_state_t model;
  seq_state_t plan;

  bit offering = 1'b0;
  int gap_left = 0;
  int burst_left = 0;
  int gap_max = 4;
  int burst_max = 8;
  int stall_pct = 30;
  int hold_left = 0;
  int items_made = 0;
  int words_seen = 0;
  int errors = 0;

  i2c_master_transaction_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // sequencer prediction
  // ---------------------------------------------------------------
  function automatic seq_state_t seq_reset();
    seq_state_t s;
    s.phase        = PH_IDLE;
    s.tries        = '0;
    s.bytes_left   = '0;
    s.done_count   = '0;
    s.pointer_sent = '0;
    s.addr         = '0;
    s.dir          = 1'b0;
    s.plen         = '0;
    s.ptr          = '0;
    s.retry_limit  = RETRY_LIMIT_RESET;
    return s;
  endfunction

  function automatic void end_xfer(inout seq_state_t s, inout res_t o,
                                   input outcome_t oc, input action_t act);
    o.done_res = 1'b1;
    o.outcome  = oc;
    o.action   = act;
    s.phase    = PH_IDLE;
  endfunction

  function automatic void put_byte(inout seq_state_t s, inout res_t o,
                                   input logic [7:0] b, input phase_t nxt);
    o.action    = ACT_SEND;
    o.send_byte = b;
    s.phase     = nxt;
  endfunction

  function automatic void start_over(inout seq_state_t s, inout res_t o);
    s.pointer_sent = '0;
    o.action       = ACT_START;
    s.phase        = PH_START;
  endfunction

  // counted start attempt, gives up once the limit is reached
  function automatic void retry_start(inout seq_state_t s, inout res_t o);
    if (s.tries >= s.retry_limit) begin
      end_xfer(s, o, OC_TRIES, ACT_NONE);
    end else begin
      s.tries = s.tries + 8'd1;
      start_over(s, o);
    end
  endfunction

  function automatic void tx_next(inout seq_state_t s, inout res_t o, input logic [7:0] tx);
    if (s.bytes_left == 0) end_xfer(s, o, OC_OK, ACT_STOP);
    else put_byte(s, o, tx, PH_TX);
  endfunction

  function automatic void rx_next(inout seq_state_t s, inout res_t o);
    if (s.bytes_left == 0) begin
      end_xfer(s, o, OC_OK, ACT_STOP);
    end else begin
      o.action = (s.bytes_left == 1) ? ACT_RX_NACK : ACT_RX_ACK;
      s.phase  = PH_RX;
    end
  endfunction

  // next pointer byte, then repeated start for reads or payload for writes
  function automatic void ptr_next(inout seq_state_t s, inout res_t o, input logic [7:0] tx);
    logic [7:0] b;
    if (s.pointer_sent < s.plen) begin
      b = (s.plen == 2 && s.pointer_sent == 0) ? s.ptr[15:8] : s.ptr[7:0];
      s.pointer_sent = s.pointer_sent + 2'd1;
      put_byte(s, o, b, PH_PTR);
    end else if (s.dir == DIR_READ) begin
      o.action = ACT_START;
      s.phase  = PH_RSTART;
    end else begin
      tx_next(s, o, tx);
    end
  endfunction

  function automatic res_t seq_step(inout seq_state_t s, input req_t r);
    res_t       o;
    logic [7:0] st;
    o  = '0;
    st = r.status_code & 8'hF8;
    if (r.cmd == CMD_BEGIN) begin
      // a begin while busy is dropped
      if (s.phase == PH_IDLE) begin
        s.addr         = r.dev_addr;
        s.dir          = r.direction;
        s.plen         = (r.pointer_len > 2) ? 2'd2 : r.pointer_len;
        s.ptr          = r.pointer_value;
        s.done_count   = '0;
        s.pointer_sent = '0;
        s.tries        = '0;
        s.bytes_left   = (r.length > MAX_LENGTH) ? MAX_LENGTH : r.length;
        retry_start(s, o);
      end
    end else begin
      case (s.phase)
        PH_START, PH_RSTART: begin
          if (r.timed_out) begin
            end_xfer(s, o, OC_START_TO, ACT_STOP);
          end else if (st == ST_START || st == ST_RSTART) begin
            if (s.phase == PH_START && (s.dir != DIR_READ || s.plen > 0))
              put_byte(s, o, {s.addr, 1'b0}, PH_SLA_W);
            else
              put_byte(s, o, {s.addr, 1'b1}, PH_SLA_R);
          end else if (st == ST_ARB_LOST) begin
            start_over(s, o);
          end else begin
            end_xfer(s, o, OC_BAD_START, ACT_NONE);
          end
        end
        PH_SLA_W: begin
          if (r.timed_out) begin
            end_xfer(s, o, OC_XFER, ACT_STOP);
          end else if (st == ST_SLA_W_ACK) begin
            s.pointer_sent = '0;
            ptr_next(s, o, r.tx_byte);
          end else if (st == ST_SLA_W_NACK) begin
            retry_start(s, o);
          end else if (st == ST_ARB_LOST) begin
            start_over(s, o);
          end else begin
            end_xfer(s, o, OC_XFER, ACT_STOP);
          end
        end
        PH_PTR: begin
          if (r.timed_out) end_xfer(s, o, OC_XFER, ACT_STOP);
          else if (st == ST_DATA_W_ACK) ptr_next(s, o, r.tx_byte);
          else if (st == ST_ARB_LOST) start_over(s, o);
          else end_xfer(s, o, OC_XFER, ACT_STOP);
        end
        PH_SLA_R: begin
          if (r.timed_out) end_xfer(s, o, OC_XFER, ACT_STOP);
          else if (st == ST_SLA_R_ACK) rx_next(s, o);
          else if (st == ST_SLA_R_NACK) retry_start(s, o);
          else if (st == ST_ARB_LOST) start_over(s, o);
          else end_xfer(s, o, OC_XFER, ACT_STOP);
        end
        PH_TX: begin
          if (!r.timed_out && st == ST_DATA_W_ACK) begin
            s.done_count = s.done_count + 8'd1;
            if (s.bytes_left > 0) s.bytes_left = s.bytes_left - 8'd1;
            tx_next(s, o, r.tx_byte);
          end else begin
            end_xfer(s, o, OC_XFER, ACT_STOP);
          end
        end
        PH_RX: begin
          if (!r.timed_out && (st == ST_DATA_R_ACK || st == ST_DATA_R_NACK)) begin
            o.read_valid = 1'b1;
            o.read_data  = r.rx_byte;
            s.done_count = s.done_count + 8'd1;
            if (s.bytes_left > 0) s.bytes_left = s.bytes_left - 8'd1;
            if (st == ST_DATA_R_NACK) end_xfer(s, o, OC_OK, ACT_STOP);
            else rx_next(s, o);
          end else begin
            end_xfer(s, o, OC_XFER, ACT_STOP);
          end
        end
        default: s.phase = PH_IDLE;
      endcase
    end
    o.byte_count = s.done_count;
    return o;
  endfunction

  // ---------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------
  function automatic req_t rand_word();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[59:0];
  endfunction

  function automatic req_t make_begin(input logic [6:0] addr, input logic dir,
                                      input logic [1:0] plen, input logic [15:0] ptr,
                                      input logic [7:0] len);
    req_t r;
    r               = rand_word();
    r.cmd           = CMD_BEGIN;
    r.dev_addr      = addr;
    r.direction     = dir;
    r.pointer_len   = plen;
    r.pointer_value = ptr;
    r.length        = len;
    return r;
  endfunction

  // status with random low bits, which the block ignores
  function automatic req_t make_report(input logic [7:0] st, input logic to);
    req_t r;
    r                  = rand_word();
    r.cmd              = CMD_REPORT;
    r.status_code[7:3] = st[7:3];
    r.timed_out        = to;
    return r;
  endfunction

  // mostly the status a healthy bus would give in this phase
  function automatic req_t pick_report(input seq_state_t g, input bit noisy);
    logic [7:0] st;
    logic       to;
    int         roll;
    roll = $urandom_range(0, 99);
    to   = 1'b0;
    case (g.phase)
      PH_START:  st = roll < 85 ? ST_START : (roll < 95 ? ST_RSTART : ST_ARB_LOST);
      PH_RSTART: st = roll < 85 ? ST_RSTART : (roll < 95 ? ST_START : ST_ARB_LOST);
      PH_SLA_W:  st = roll < 80 ? ST_SLA_W_ACK : (roll < 92 ? ST_SLA_W_NACK : ST_ARB_LOST);
      PH_PTR:    st = roll < 92 ? ST_DATA_W_ACK : ST_ARB_LOST;
      PH_SLA_R:  st = roll < 80 ? ST_SLA_R_ACK : (roll < 92 ? ST_SLA_R_NACK : ST_ARB_LOST);
      PH_TX:     st = ST_DATA_W_ACK;
      PH_RX:     st = (g.bytes_left == 1 || roll < 3) ? ST_DATA_R_NACK : ST_DATA_R_ACK;
      default:   st = 8'($urandom_range(0, 255));
    endcase
    if (noisy) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) to = 1'b1;
      else if (roll < 6) st = 8'($urandom_range(0, 255));
    end
    return make_report(st, to);
  endfunction

  // ignored words do not count toward the stimulus size
  task automatic queue_word(input req_t r);
    if ((r.cmd == CMD_BEGIN) == (plan.phase == PH_IDLE)) items_made++;
    void'(seq_step(plan, r));
    pending_q.push_back(r);
  endtask

  task automatic add_transaction(input int fixed_len, input bit noisy);
    int len;
    int steps;
    int roll;
    roll = $urandom_range(0, 99);
    if (fixed_len >= 0) len = fixed_len;
    else if (roll < 60) len = $urandom_range(0, 3);
    else if (roll < 90) len = $urandom_range(4, 16);
    else len = $urandom_range(17, 64);
    queue_word(make_begin(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                          2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                          8'(len)));
    steps = 0;
    while (plan.phase != PH_IDLE && steps < len + 30) begin
      if (noisy && $urandom_range(0, 99) < 2) queue_word(rand_word() & ~(60'(1) << 59));
      queue_word(pick_report(plan, noisy));
      steps++;
    end
    // a timeout ends the transaction from any phase
    if (plan.phase != PH_IDLE) queue_word(make_report(ST_START, 1'b1));
    if (noisy && $urandom_range(0, 99) < 10)
      queue_word(make_report(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || offering || expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    model.retry_limit = v;
    plan.retry_limit  = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("result %0d: %s is %0h, expected %0h", words_seen, what, got, want);
  endtask

  // ---------------------------------------------------------------
  // request driver: bursts with random gaps, word held while stalled
  // ---------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!offering) begin
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        req       <= pending_q.pop_front();
        req_valid <= 1'b1;
        offering  = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, burst_max);
          gap_left   = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // result stall: random pattern, or a long hold when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else begin
      res_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: predict on each accepted word, check each delivered word
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        expected_q.push_back(seq_step(model, req));
        offering = 1'b0;
      end
      if (res_valid && !res_stall) begin
        words_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("unrequested word, action", res.action, ACT_NONE);
        end else begin
          want = expected_q.pop_front();
          if (res.action !== want.action)
            report_mismatch("action", res.action, want.action);
          if (res.send_byte !== want.send_byte)
            report_mismatch("send_byte", res.send_byte, want.send_byte);
          if (res.read_data !== want.read_data)
            report_mismatch("read_data", res.read_data, want.read_data);
          if (res.read_valid !== want.read_valid)
            report_mismatch("read_valid", res.read_valid, want.read_valid);
          if (res.done_res !== want.done_res)
            report_mismatch("done_res", res.done_res, want.done_res);
          if (res.outcome !== want.outcome)
            report_mismatch("outcome", res.outcome, want.outcome);
          if (res.byte_count !== want.byte_count)
            report_mismatch("byte_count", res.byte_count, want.byte_count);
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------
  initial begin
    logic [7:0] limits [7];
    int         start;
    limits = '{8'd255, 8'd1, 8'd3, 8'd8, 8'd2, 8'd255, 8'd5};
    model  = seq_reset();
    plan   = seq_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // report while idle, then a two-byte pointer write with no payload;
    // pointer length three, a begin while busy, arbitration loss before payload
    queue_word(make_report(ST_START, 1'b0));
    queue_word(make_begin(7'h7F, 1'b0, 2'd3, 16'hFFFF, 8'd0));
    queue_word(make_report(ST_START, 1'b0));
    queue_word(make_begin(7'h00, 1'b0, 2'd0, 16'h0000, 8'd0));
    queue_word(make_report(ST_SLA_W_ACK, 1'b0));
    queue_word(make_report(ST_ARB_LOST, 1'b0));
    queue_word(make_report(ST_RSTART, 1'b0));
    queue_word(make_report(ST_SLA_W_ACK, 1'b0));
    queue_word(make_report(ST_DATA_W_ACK, 1'b0));
    queue_word(make_report(ST_DATA_W_ACK, 1'b0));
    // one-byte pointer read via repeated start, ended early by a data nack
    queue_word(make_begin(7'h00, DIR_READ, 2'd1, 16'h12A5, 8'd2));
    queue_word(make_report(ST_START, 1'b0));
    queue_word(make_report(ST_SLA_W_ACK, 1'b0));
    queue_word(make_report(ST_DATA_W_ACK, 1'b0));
    queue_word(make_report(ST_RSTART, 1'b0));
    queue_word(make_report(ST_SLA_R_ACK, 1'b0));
    queue_word(make_report(ST_DATA_R_NACK, 1'b0));
    // arbitration lost inside the payload
    queue_word(make_begin(7'h55, 1'b0, 2'd0, 16'h0000, 8'd3));
    queue_word(make_report(ST_START, 1'b0));
    queue_word(make_report(ST_SLA_W_ACK, 1'b0));
    queue_word(make_report(ST_ARB_LOST, 1'b0));
    // start timeout on a full-length read, then a bad start status
    queue_word(make_begin(7'h01, DIR_READ, 2'd0, 16'h0000, MAX_LENGTH));
    queue_word(make_report(ST_START, 1'b1));
    queue_word(make_begin(7'h02, DIR_READ, 2'd0, 16'h0000, 8'd0));
    queue_word(make_report(8'h60, 1'b0));
    wait_drained();

    // address nack exhausting a limit of one, then a limit of zero
    write_limit(8'd1);
    queue_word(make_begin(7'h03, DIR_READ, 2'd0, 16'hFFFF, 8'd1));
    queue_word(make_report(ST_START, 1'b0));
    queue_word(make_report(ST_SLA_R_NACK, 1'b0));
    queue_word(make_report(ST_START, 1'b0));
    queue_word(make_report(ST_SLA_R_NACK, 1'b0));
    wait_drained();
    write_limit(8'd0);
    queue_word(make_begin(7'h04, 1'b0, 2'd2, 16'h8001, 8'd1));
    wait_drained();

    // random transactions under several retry limits and idling styles
    for (int p = 0; p < 7; p++) begin
      write_limit(limits[p]);
      gap_max   = (p % 3 == 0) ? 0 : $urandom_range(1, 12);
      burst_max = $urandom_range(1, 16);
      stall_pct = (p % 3 == 1) ? 0 : $urandom_range(10, 75);
      // long result hold with the sender pushing until the input backs up
      if (p == 1) begin
        gap_max   = 0;
        hold_left = 300;
      end
      start = items_made;
      if (p == 3) add_transaction(MAX_LENGTH, 1'b0);
      while (items_made - start < 270) add_transaction(-1, 1'b1);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // run time guard
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/i2cmts_pkg.sv
hw/rtl/i2c_master_transaction_sequencer.sv
hw/rtl/i2cmts_checker.sv
dv/i2c_master_transaction_sequencer_tb.sv
